@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the compositor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check a property on every rising clock edge outside reset.
`define PACOMP_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("pacomp assertion failed");

// Check that the antecedent implies the consequent in the following clock cycle.
`define PACOMP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pacomp assertion failed");

`else

`define PACOMP_ASSERT(label, clk, rst_n, prop)
`define PACOMP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ hw/rtl/pacomp_pkg.sv @@
// Types and constants of the palette alpha-blend compositor.
package pacomp_pkg;

  localparam int unsigned PALETTE_ENTRIES_DEFAULT = 256;

  // Register reset values
  localparam logic [3:0]  BRIGHTNESS_RESET = 4'd15;
  localparam logic        ENCODING_RESET   = 1'b0;
  localparam logic        PROTECT_RESET    = 1'b0;
  localparam logic [31:0] BACKDROP_RESET   = 32'd0;

  // x / 15 for x < 3840 as (x * 2185) >> 15
  localparam logic [11:0] RECIP15       = 12'd2185;
  localparam int unsigned RECIP15_SHIFT = 15;
  // x / 255 for x < 65536 as (x * 32897) >> 23
  localparam logic [15:0] RECIP255       = 16'd32897;
  localparam int unsigned RECIP255_SHIFT = 23;

  localparam logic [7:0] ALPHA_MAX  = 8'd255;
  localparam logic [7:0] ROUND_BIAS = 8'd127;

  typedef enum logic [1:0] {
    CFG_BRIGHTNESS = 2'd0,
    CFG_ENCODING   = 2'd1,
    CFG_PROTECT    = 2'd2,
    CFG_BACKDROP   = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    CMD_PALETTE_WRITE = 1'b0,
    CMD_COMPOSITE     = 1'b1
  } cmd_e;

  // Control travelling alongside each pipeline stage
  typedef struct packed {
    logic valid;
    logic allowed;
  } stage_ctrl_t;

endpackage

@@ hw/rtl/palette_alpha_blend_compositor_unit.sv @@
// Top level of the palette alpha-blend compositor.
//
//  channel  | handshake                       | payload
//  ---------+---------------------------------+--------------------------------------------
//  input    | in_valid_i / in_stall_o         | command, palette_slot, source_rgba,
//           |                                 | source_index, dest_argb
//  output   | out_valid_o / out_stall_i       | out_argb, write_enable
//  config   | cfg_we_i                        | cfg_index_i, cfg_data_i
//
// One item per clock while out_stall_i does not hold the pipeline; five register stages,
// the first loaded by the edge that takes the item, the last holding the result:
// palette read, scale, divide by 15, blend, divide by 255 into the output register.
// Palette writes leave no result and are written at the edge that takes them; the
// palette has no clear pass, so unwritten entries read as whatever the memory holds.
// Reset clears the valid bits and sets the registers to their defaults.
// While a result waits under out_stall_i the whole pipeline holds and in_stall_o is high.
`include "assert_macros.svh"

module palette_alpha_blend_compositor_unit #(
  parameter int unsigned PALETTE_ENTRIES = pacomp_pkg::PALETTE_ENTRIES_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [7:0]  palette_slot_i,
  input  logic [31:0] source_rgba_i,
  input  logic [7:0]  source_index_i,
  input  logic [31:0] dest_argb_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] out_argb_o,
  output logic        write_enable_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned AddrW = $clog2(PALETTE_ENTRIES);

  logic [3:0]  brightness_q;
  logic        encoding_q;
  logic        protect_q;
  logic [31:0] backdrop_q;

  logic advance, accept, slot_ok, idx_ok, allowed;
  logic pal_we;

  pacomp_pkg::stage_ctrl_t ctrl1_q, ctrl1_d, ctrl_out;
  logic        direct1_q, idx_ok1_q;
  logic [31:0] rgba1_q, dest1_q;
  logic [31:0] pal_rdata, src1;

  assign advance    = !out_valid_o || !out_stall_i;
  assign in_stall_o = !advance;
  assign accept     = in_valid_i && advance;

  assign slot_ok = {1'b0, palette_slot_i} < 9'(PALETTE_ENTRIES);
  assign idx_ok  = {1'b0, source_index_i} < 9'(PALETTE_ENTRIES);
  assign pal_we  = accept && (command_i == pacomp_pkg::CMD_PALETTE_WRITE) && slot_ok;

  assign allowed = (brightness_q != 4'd0) &&
                   (!protect_q || (dest_argb_i == backdrop_q) || (dest_argb_i[31:24] == 8'd0));

  always_comb begin
    ctrl1_d.valid   = accept && (command_i == pacomp_pkg::CMD_COMPOSITE);
    ctrl1_d.allowed = allowed;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brightness_q <= pacomp_pkg::BRIGHTNESS_RESET;
      encoding_q   <= pacomp_pkg::ENCODING_RESET;
      protect_q    <= pacomp_pkg::PROTECT_RESET;
      backdrop_q   <= pacomp_pkg::BACKDROP_RESET;
    end else if (cfg_we_i) begin
      unique case (pacomp_pkg::cfg_idx_e'(cfg_index_i))
        pacomp_pkg::CFG_BRIGHTNESS: brightness_q <= cfg_data_i[3:0];
        pacomp_pkg::CFG_ENCODING:   encoding_q   <= cfg_data_i[0];
        pacomp_pkg::CFG_PROTECT:    protect_q    <= cfg_data_i[0];
        pacomp_pkg::CFG_BACKDROP:   backdrop_q   <= cfg_data_i;
        default:                    ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl1_q <= '0;
    end else if (advance) begin
      ctrl1_q <= ctrl1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      direct1_q <= encoding_q;
      idx_ok1_q <= idx_ok;
      rgba1_q   <= source_rgba_i;
      dest1_q   <= dest_argb_i;
    end
  end

  pacomp_palette #(
    .Entries (PALETTE_ENTRIES)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (palette_slot_i[AddrW-1:0]),
    .wdata_i (source_rgba_i),
    .re_i    (advance),
    .raddr_i (source_index_i[AddrW-1:0]),
    .rdata_o (pal_rdata)
  );

  // direct source, palette entry, or transparent black past the palette end
  always_comb begin
    if (direct1_q) begin
      src1 = rgba1_q;
    end else if (idx_ok1_q) begin
      src1 = pal_rdata;
    end else begin
      src1 = 32'd0;
    end
  end

  pacomp_blend u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (advance),
    .ctrl_i      (ctrl1_q),
    .src_rgba_i  (src1),
    .dest_argb_i (dest1_q),
    .scale_i     (brightness_q),
    .ctrl_o      (ctrl_out),
    .out_argb_o  (out_argb_o)
  );

  assign out_valid_o    = ctrl_out.valid;
  assign write_enable_o = ctrl_out.allowed;

  `PACOMP_ASSERT(a_stall_only_on_wait, clk_i, rst_ni, !in_stall_o || out_valid_o)
  `PACOMP_ASSERT_NEXT(a_frozen_result_holds, clk_i, rst_ni, in_stall_o,
                      $stable(out_argb_o) && $stable(write_enable_o) && out_valid_o)
  `PACOMP_ASSERT_NEXT(a_palette_write_no_result, clk_i, rst_ni,
                      accept && (command_i == pacomp_pkg::CMD_PALETTE_WRITE),
                      !ctrl1_q.valid)
  `PACOMP_ASSERT_NEXT(a_suppressed_passes_dest, clk_i, rst_ni,
                      advance && ctrl1_d.valid && !allowed,
                      !ctrl1_q.allowed && (dest1_q == $past(dest_argb_i)))

endmodule

@@ hw/rtl/pacomp_palette.sv @@
// Palette memory: one write port, one registered read port.
module pacomp_palette #(
  parameter int unsigned Entries = pacomp_pkg::PALETTE_ENTRIES_DEFAULT
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(Entries)-1:0] waddr_i,
  input  logic [31:0]                wdata_i,
  input  logic                       re_i,
  input  logic [$clog2(Entries)-1:0] raddr_i,
  output logic [31:0]                rdata_o
);

  logic [31:0] mem [Entries];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // hold the read data while the pipeline is frozen
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/pacomp_blend.sv @@
// Scale and blend pipeline: brightness scale, divide by 15, blend, divide by 255.
module pacomp_blend (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  pacomp_pkg::stage_ctrl_t   ctrl_i,
  input  logic [31:0]               src_rgba_i,
  input  logic [31:0]               dest_argb_i,
  input  logic [3:0]                scale_i,
  output pacomp_pkg::stage_ctrl_t   ctrl_o,
  output logic [31:0]               out_argb_o
);

  // Lane 0 red, 1 green, 2 blue
  pacomp_pkg::stage_ctrl_t ctrl2_q, ctrl3_q, ctrl4_q, ctrl5_q;
  logic [31:0] dest2_q, dest3_q, dest4_q;
  logic [7:0]  alpha2_q, alpha3_q, alpha4_q;
  logic [11:0] prod2_q [3];
  logic [7:0]  chan3_q [3];
  logic [15:0] sum4_q [4];
  logic [31:0] out5_q;

  logic [11:0] prod2_d [3];
  logic [7:0]  chan3_d [3];
  logic [15:0] sum4_d [4];
  logic [31:0] out5_d;

  logic [23:0] div15_prod [3];
  logic [7:0]  inv_alpha;
  logic [7:0]  dest_chan [4];
  logic [31:0] div255_prod [4];
  logic [7:0]  quot [4];
  logic [7:0]  out_alpha;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod2_d[c] = {4'd0, src_rgba_i[8*c +: 8]} * {8'd0, scale_i};
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      div15_prod[c] = {12'd0, prod2_q[c]} * {12'd0, pacomp_pkg::RECIP15};
      chan3_d[c]    = div15_prod[c][pacomp_pkg::RECIP15_SHIFT +: 8];
    end
  end

  // Lane 3 is the destination alpha term
  always_comb begin
    inv_alpha    = pacomp_pkg::ALPHA_MAX - alpha3_q;
    dest_chan[0] = dest3_q[23:16];
    dest_chan[1] = dest3_q[15:8];
    dest_chan[2] = dest3_q[7:0];
    dest_chan[3] = dest3_q[31:24];
    for (int c = 0; c < 3; c++) begin
      sum4_d[c] = {8'd0, chan3_q[c]} * {8'd0, alpha3_q}
                + {8'd0, dest_chan[c]} * {8'd0, inv_alpha}
                + {8'd0, pacomp_pkg::ROUND_BIAS};
    end
    sum4_d[3] = {8'd0, dest_chan[3]} * {8'd0, inv_alpha}
              + {8'd0, pacomp_pkg::ROUND_BIAS};
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      div255_prod[c] = {16'd0, sum4_q[c]} * {16'd0, pacomp_pkg::RECIP255};
      quot[c]        = div255_prod[c][pacomp_pkg::RECIP255_SHIFT +: 8];
    end
    out_alpha = alpha4_q + quot[3];
    if (ctrl4_q.allowed) begin
      out5_d = {out_alpha, quot[0], quot[1], quot[2]};
    end else begin
      out5_d = dest4_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl2_q <= '0;
      ctrl3_q <= '0;
      ctrl4_q <= '0;
      ctrl5_q <= '0;
    end else if (en_i) begin
      ctrl2_q <= ctrl_i;
      ctrl3_q <= ctrl2_q;
      ctrl4_q <= ctrl3_q;
      ctrl5_q <= ctrl4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod2_q  <= prod2_d;
      alpha2_q <= src_rgba_i[31:24];
      dest2_q  <= dest_argb_i;
      chan3_q  <= chan3_d;
      alpha3_q <= alpha2_q;
      dest3_q  <= dest2_q;
      sum4_q   <= sum4_d;
      alpha4_q <= alpha3_q;
      dest4_q  <= dest3_q;
      out5_q   <= out5_d;
    end
  end

  assign ctrl_o     = ctrl5_q;
  assign out_argb_o = out5_q;

endmodule

@@ bench/palette_alpha_blend_compositor_unit_tb.sv @@
// Self-checking bench for the palette alpha-blend compositor: palette loads and blended pixels.
module palette_alpha_blend_compositor_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PAL_DEPTH     = 256;
  localparam int unsigned DIM_STEPS     = 15;
  localparam int unsigned FULL_ALPHA    = 255;
  localparam int unsigned HALF_UP       = 127;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned STUCK_LIMIT   = 3000;
  localparam int unsigned RAND_PHASES   = 12;
  localparam int unsigned PHASE_ITEMS   = 140;

  typedef struct {
    pacomp_pkg::cmd_e cmd;
    logic [7:0]       slot;
    logic [31:0]      rgba;
    logic [7:0]       idx;
    logic [31:0]      dst;
    bit               hold_first;
  } blend_job_t;

  typedef struct {
    logic [31:0] argb;
    logic        we;
  } pixel_out_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic        command_i      = 1'b0;
  logic [7:0]  palette_slot_i = 8'd0;
  logic [31:0] source_rgba_i  = 32'd0;
  logic [7:0]  source_index_i = 8'd0;
  logic [31:0] dest_argb_i    = 32'd0;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic [31:0] out_argb_o;
  logic        write_enable_o;
  logic        cfg_we_i       = 1'b0;
  logic [1:0]  cfg_index_i    = 2'd0;
  logic [31:0] cfg_data_i     = 32'd0;

  // Register copies, changed only while the block is idle
  logic [3:0]  dim_level   = pacomp_pkg::BRIGHTNESS_RESET;
  logic        direct_src  = pacomp_pkg::ENCODING_RESET;
  logic        guard_on    = pacomp_pkg::PROTECT_RESET;
  logic [31:0] backdrop_px = pacomp_pkg::BACKDROP_RESET;

  logic [31:0] pal_shadow [PAL_DEPTH];
  bit          slot_loaded [PAL_DEPTH];
  logic [7:0]  loaded_slots [$];

  blend_job_t  pixel_jobs [$];
  pixel_out_t  pixels_due [$];
  blend_job_t  cur_job;

  int unsigned jobs_queued   = 0;
  int unsigned jobs_taken    = 0;
  int unsigned mismatches    = 0;
  int unsigned send_gap      = 0;
  int unsigned recv_gap      = 0;
  int unsigned stuck_cycles  = 0;
  bit          send_bursts   = 1'b1;
  bit          recv_bursts   = 1'b1;

  palette_alpha_blend_compositor_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .palette_slot_i (palette_slot_i),
    .source_rgba_i  (source_rgba_i),
    .source_index_i (source_index_i),
    .dest_argb_i    (dest_argb_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_argb_o     (out_argb_o),
    .write_enable_o (write_enable_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- prediction

  function automatic logic [7:0] dim_channel(logic [7:0] c, logic [3:0] lvl);
    logic [11:0] prod;
    prod = 12'(c) * 12'(lvl);
    return 8'(prod / 12'(DIM_STEPS));
  endfunction

  function automatic logic [7:0] mix_channel(logic [7:0] s, logic [7:0] a, logic [7:0] d);
    logic [16:0] acc;
    acc = 17'(s) * 17'(a) + 17'(d) * 17'(8'(FULL_ALPHA) - a) + 17'(HALF_UP);
    return 8'(acc / 17'(FULL_ALPHA));
  endfunction

  function automatic logic [31:0] blend_over(logic [31:0] src, logic [31:0] dst,
                                              logic [3:0] lvl);
    logic [7:0] a;
    logic [7:0] oa;
    a  = src[31:24];
    // Coverage alpha is a blend of zero colour plus the source alpha itself
    oa = a + mix_channel(8'd0, a, dst[31:24]);
    return {oa,
            mix_channel(dim_channel(src[7:0], lvl), a, dst[23:16]),
            mix_channel(dim_channel(src[15:8], lvl), a, dst[15:8]),
            mix_channel(dim_channel(src[23:16], lvl), a, dst[7:0])};
  endfunction

  task automatic apply_job(blend_job_t j);
    logic [31:0] src;
    pixel_out_t  res;
    if (j.cmd == pacomp_pkg::CMD_PALETTE_WRITE) begin
      if (j.slot < PAL_DEPTH) pal_shadow[j.slot] = j.rgba;
    end else begin
      if (direct_src) src = j.rgba;
      else if (j.idx < PAL_DEPTH) src = pal_shadow[j.idx];
      else src = 32'd0;
      if (dim_level != 4'd0 &&
          (!guard_on || j.dst == backdrop_px || j.dst[31:24] == 8'd0)) begin
        res.argb = blend_over(src, j.dst, dim_level);
        res.we   = 1'b1;
      end else begin
        res.argb = j.dst;
        res.we   = 1'b0;
      end
      pixels_due.push_back(res);
    end
  endtask

  // ---------------------------------------------------------------- stimulus

  task automatic push_job(pacomp_pkg::cmd_e c, logic [7:0] s, logic [31:0] rgba,
                          logic [7:0] i, logic [31:0] d);
    blend_job_t j;
    j.cmd = c;
    j.slot = s;
    j.rgba = rgba;
    j.idx = i;
    j.dst = d;
    j.hold_first = 1'b0;
    // Track loads here so indexed pixels only ever read loaded entries
    if (c == pacomp_pkg::CMD_PALETTE_WRITE && !slot_loaded[s]) begin
      slot_loaded[s] = 1'b1;
      loaded_slots.push_back(s);
    end
    pixel_jobs.push_back(j);
    jobs_queued++;
  endtask

  function automatic logic [31:0] rand_colour();
    logic [31:0] c;
    c = $urandom;
    case ($urandom_range(0, 9))
      0: c[31:24] = 8'h00;
      1: c[31:24] = 8'hff;
      2: c = 32'hffff_ffff;
      3: c = 32'h0000_0000;
      default: ;
    endcase
    return c;
  endfunction

  function automatic logic [31:0] rand_dest();
    logic [31:0] d;
    d = rand_colour();
    if (guard_on) begin
      case ($urandom_range(0, 3))
        0: d = backdrop_px;
        1: d[31:24] = 8'h00;
        2: d = backdrop_px ^ (32'd1 << $urandom_range(0, 31));
        default: ;
      endcase
    end
    return d;
  endfunction

  task automatic write_reg(pacomp_pkg::cfg_idx_e i, logic [31:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= i;
    cfg_data_i  <= v;
  endtask

  task automatic program_regs(logic [3:0] lvl, logic enc, logic prot, logic [31:0] bd);
    write_reg(pacomp_pkg::CFG_BRIGHTNESS, 32'(lvl));
    write_reg(pacomp_pkg::CFG_ENCODING, 32'(enc));
    write_reg(pacomp_pkg::CFG_PROTECT, 32'(prot));
    write_reg(pacomp_pkg::CFG_BACKDROP, bd);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    dim_level   = lvl;
    direct_src  = enc;
    guard_on    = prot;
    backdrop_px = bd;
  endtask

  // Wait for every item to be taken and every pixel to come back, then let
  // trailing palette loads leave the pipeline.
  task automatic settle();
    while (jobs_taken != jobs_queued || pixels_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic fill_random(int unsigned n);
    logic [7:0] i;
    for (int unsigned k = 0; k < n; k++) begin
      if ($urandom_range(0, 4) == 0) begin
        push_job(pacomp_pkg::CMD_PALETTE_WRITE, 8'($urandom), rand_colour(),
                 8'($urandom), $urandom);
      end else begin
        if (direct_src) i = 8'($urandom);
        else i = loaded_slots[$urandom_range(0, loaded_slots.size() - 1)];
        push_job(pacomp_pkg::CMD_COMPOSITE, 8'($urandom), rand_colour(), i, rand_dest());
      end
      // Pause the sender once per phase until the pipeline has emptied
      if (k == n / 2) pixel_jobs[pixel_jobs.size() - 1].hold_first = 1'b1;
    end
  endtask

  initial begin
    logic [3:0]  lvl;
    logic        enc;
    logic        prot;
    logic [31:0] bd;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: indexed source, full brightness, no protection
    push_job(pacomp_pkg::CMD_PALETTE_WRITE, 8'd0,   32'h0000_0000, 8'd0, 32'd0);
    push_job(pacomp_pkg::CMD_PALETTE_WRITE, 8'd255, 32'hffff_ffff, 8'd0, 32'd0);
    push_job(pacomp_pkg::CMD_PALETTE_WRITE, 8'd128, 32'h80ff_007f, 8'd0, 32'd0);
    push_job(pacomp_pkg::CMD_PALETTE_WRITE, 8'd1,   32'hff00_ff00, 8'd0, 32'd0);
    push_job(pacomp_pkg::CMD_COMPOSITE, 8'd0, 32'd0, 8'd0,   32'hffff_ffff);
    push_job(pacomp_pkg::CMD_COMPOSITE, 8'd0, 32'd0, 8'd255, 32'h0000_0000);
    push_job(pacomp_pkg::CMD_COMPOSITE, 8'd0, 32'd0, 8'd128, 32'h8080_8080);
    push_job(pacomp_pkg::CMD_COMPOSITE, 8'd0, 32'd0, 8'd1,   32'h0012_3456);
    // Reload an entry and read it back on the next item
    push_job(pacomp_pkg::CMD_PALETTE_WRITE, 8'd0, 32'h7f10_2030, 8'd0, 32'd0);
    push_job(pacomp_pkg::CMD_COMPOSITE, 8'd0, 32'd0, 8'd0, 32'hff40_c0ff);
    settle();

    program_regs(4'd15, 1'b1, 1'b0, 32'd0);
    push_job(pacomp_pkg::CMD_COMPOSITE, 8'd0, 32'hffff_ffff, 8'd255, 32'h0000_0000);
    push_job(pacomp_pkg::CMD_COMPOSITE, 8'd0, 32'h0000_0000, 8'd0,   32'hffff_ffff);
    push_job(pacomp_pkg::CMD_COMPOSITE, 8'd0, 32'hff00_00ff, 8'd7,   32'h5a3c_96e1);
    push_job(pacomp_pkg::CMD_COMPOSITE, 8'd0, 32'h8080_8080, 8'd200, 32'h8080_8080);
    settle();

    // Brightness zero: nothing is written
    program_regs(4'd0, 1'b1, 1'b0, 32'd0);
    push_job(pacomp_pkg::CMD_COMPOSITE, 8'd0, 32'hffff_ffff, 8'd0, 32'h1234_5678);
    push_job(pacomp_pkg::CMD_PALETTE_WRITE, 8'd77, 32'h4488_cc11, 8'd0, 32'd0);
    push_job(pacomp_pkg::CMD_COMPOSITE, 8'd0, 32'h80ff_ffff, 8'd0, 32'h0000_0000);
    settle();

    // Protection: backdrop and transparent pass, anything else is held
    program_regs(4'd9, 1'b0, 1'b1, 32'ha5a5_a5a5);
    push_job(pacomp_pkg::CMD_COMPOSITE, 8'd0, 32'd0, 8'd128, 32'ha5a5_a5a5);
    push_job(pacomp_pkg::CMD_COMPOSITE, 8'd0, 32'd0, 8'd255, 32'h00ff_ffff);
    push_job(pacomp_pkg::CMD_COMPOSITE, 8'd0, 32'd0, 8'd77,  32'h0100_0000);
    push_job(pacomp_pkg::CMD_COMPOSITE, 8'd0, 32'd0, 8'd1,   32'hffff_ffff);
    settle();

    for (int unsigned p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0:       lvl = 4'd15;
        1:       lvl = 4'd0;
        2:       lvl = 4'd1;
        default: lvl = 4'($urandom_range(1, 15));
      endcase
      enc  = p[0];
      prot = (p % 3 == 1);
      case (p)
        4:       bd = 32'hffff_ffff;
        7:       bd = 32'h0000_0000;
        default: bd = $urandom;
      endcase
      send_bursts = (p != 5 && p < RAND_PHASES - 2);
      recv_bursts = send_bursts;
      program_regs(lvl, enc, prot, bd);
      fill_random(PHASE_ITEMS);
      settle();
    end

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // ---------------------------------------------------------------- driver

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        apply_job(cur_job);
        jobs_taken++;
      end
      // Hold the payload while stalled; otherwise advance
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pixel_jobs.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (pixel_jobs[0].hold_first && pixels_due.size() != 0) begin
          in_valid_i <= 1'b0;
        end else if (send_bursts && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(0, 13);
          in_valid_i <= 1'b0;
        end else begin
          cur_job = pixel_jobs.pop_front();
          command_i      <= cur_job.cmd;
          palette_slot_i <= cur_job.slot;
          source_rgba_i  <= cur_job.rgba;
          source_index_i <= cur_job.idx;
          dest_argb_i    <= cur_job.dst;
          in_valid_i     <= 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk_i) begin
    pixel_out_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pixels_due.size() == 0) begin
          $display("%0t: pixel with none expected, actual argb %08h we %0b",
                   $time, out_argb_o, write_enable_o);
          mismatches++;
        end else begin
          want = pixels_due.pop_front();
          if (out_argb_o !== want.argb) begin
            $display("%0t: out_argb expected %08h actual %08h", $time, want.argb, out_argb_o);
            mismatches++;
          end
          if (write_enable_o !== want.we) begin
            $display("%0t: write_enable expected %0b actual %0b",
                     $time, want.we, write_enable_o);
            mismatches++;
          end
        end
      end
      if (recv_gap != 0) begin
        recv_gap--;
        out_stall_i <= 1'b1;
      end else if (recv_bursts && $urandom_range(0, 9) == 0) begin
        recv_gap = $urandom_range(0, 13);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d pixels outstanding",
                 $time, STUCK_LIMIT, pixels_due.size());
        $display("RESULT: ERROR");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

endmodule
